[hdl/spmp_pkg.sv]
package spmp_pkg;

	localparam int unsigned HDR_BYTES = 7;
	localparam int unsigned ID_BYTES = 2;
	localparam logic [7:0] MAX_PHASE_RESET = 8'd32;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_PHASE = 1'b0;

	// field load carried out by the back end
	typedef enum logic [2:0] {
		LD_NONE,
		LD_ID,
		LD_TS,
		LD_GROUP,
		LD_STATE,
		LD_HAS,
		LD_TIMEHI,
		LD_TIMELO
	} load_t;

	typedef enum logic [2:0] {
		ST_PHASE    = 3'd0,
		ST_OK       = 3'd1,
		ST_SHORT    = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_BADCOUNT = 3'd4
	} status_t;

	// one classified byte, front to back
	typedef struct packed {
		load_t       load;
		logic [7:0]  data;
		logic        emit;
		logic        hdr;
		logic        phase;
		logic [7:0]  idx;
		status_t     status;
		logic        mend;
	} op_t;

endpackage

[hdl/spmp_ifs.sv]
interface spmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface spmp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] intersection_id;
	logic [31:0] timestamp_ms;
	logic [7:0]  phase_index;
	logic [7:0]  signal_group;
	logic [7:0]  phase_state;
	logic        has_time;
	logic [15:0] time_to_change_ms;
	logic [2:0]  status;
	logic        message_end;

	modport source (
		output valid, output intersection_id, output timestamp_ms, output phase_index,
		output signal_group, output phase_state, output has_time,
		output time_to_change_ms, output status, output message_end, input ready
	);
	modport sink (
		input valid, input intersection_id, input timestamp_ms, input phase_index,
		input signal_group, input phase_state, input has_time,
		input time_to_change_ms, input status, input message_end, output ready
	);
endinterface

[hdl/spmp_front.sv]
module spmp_front (
	input  logic              clk,
	input  logic              arst_n,
	spmp_in_if.sink           msg,
	input  logic [7:0]        max_phase,
	input  logic              q_full,
	output logic              push,
	output spmp_pkg::op_t     op
);

	typedef enum logic [2:0] {
		P_HEADER,
		P_GROUP,
		P_STATE,
		P_HASTIME,
		P_TIMEHI,
		P_TIMELO
	} pos_t;

	pos_t       pos_q, pos_d;
	logic [2:0] hcnt_q, hcnt_d;
	logic [7:0] expect_q, expect_d;
	logic [7:0] done_q, done_d;
	logic       skip_q, skip_d;
	logic [7:0] done_inc;
	logic       b;
	logic       e;

	assign msg.ready = !q_full;
	assign push = msg.valid && !q_full;
	assign e = msg.buffer_end;
	assign b = (msg.data_byte != 8'd0);
	assign done_inc = done_q + 8'd1;

	always_comb begin
		pos_d = pos_q;
		hcnt_d = hcnt_q;
		expect_d = expect_q;
		done_d = done_q;
		skip_d = skip_q;
		op = '0;
		op.load = spmp_pkg::LD_NONE;
		op.status = spmp_pkg::ST_PHASE;
		op.data = msg.data_byte;
		op.idx = done_q;
		op.hdr = 1'b1;

		if (skip_q) begin
			if (e) begin
				skip_d = 1'b0;
				pos_d = P_HEADER;
				hcnt_d = '0;
			end
		end else begin
			case (pos_q)
				P_HEADER: begin
					if (hcnt_q == 3'(spmp_pkg::HDR_BYTES - 1)) begin
						expect_d = msg.data_byte;
						done_d = '0;
						hcnt_d = '0;
						op.idx = '0;
						if (!b) begin
							op.emit = 1'b1;
							op.status = spmp_pkg::ST_BADCOUNT;
							op.mend = 1'b1;
							if (!e) skip_d = 1'b1;
						end else if (e) begin
							// count byte was the last one
							op.emit = 1'b1;
							op.status = spmp_pkg::ST_TRUNC;
							op.mend = 1'b1;
						end else begin
							pos_d = P_GROUP;
						end
					end else begin
						op.load = (hcnt_q < 3'(spmp_pkg::ID_BYTES)) ? spmp_pkg::LD_ID
							: spmp_pkg::LD_TS;
						hcnt_d = hcnt_q + 3'd1;
						if (e) begin
							op.emit = 1'b1;
							op.hdr = 1'b0;
							op.idx = '0;
							op.status = spmp_pkg::ST_SHORT;
							op.mend = 1'b1;
							hcnt_d = '0;
						end
					end
				end
				P_GROUP, P_STATE, P_TIMEHI, P_HASTIME, P_TIMELO: begin
					case (pos_q)
						P_GROUP: begin
							op.load = spmp_pkg::LD_GROUP;
							pos_d = P_STATE;
						end
						P_STATE: begin
							op.load = spmp_pkg::LD_STATE;
							pos_d = P_HASTIME;
						end
						P_HASTIME: begin
							op.load = spmp_pkg::LD_HAS;
							pos_d = P_TIMEHI;
						end
						P_TIMEHI: begin
							op.load = spmp_pkg::LD_TIMEHI;
							pos_d = P_TIMELO;
						end
						default: begin
							op.load = spmp_pkg::LD_TIMELO;
						end
					endcase
					if (pos_q == P_TIMELO || (pos_q == P_HASTIME && !b)) begin
						// phase complete
						done_d = done_inc;
						op.emit = 1'b1;
						op.phase = 1'b1;
						if (done_inc == expect_q) begin
							op.status = (expect_q > max_phase) ? spmp_pkg::ST_BADCOUNT
								: spmp_pkg::ST_OK;
							op.mend = 1'b1;
							if (e) begin
								pos_d = P_HEADER;
							end else begin
								skip_d = 1'b1;
							end
						end else if (e) begin
							op.status = spmp_pkg::ST_TRUNC;
							op.mend = 1'b1;
							pos_d = P_HEADER;
						end else begin
							pos_d = P_GROUP;
						end
					end else if (e) begin
						op.emit = 1'b1;
						op.status = spmp_pkg::ST_TRUNC;
						op.mend = 1'b1;
						pos_d = P_HEADER;
					end
				end
				default: begin
					pos_d = P_HEADER;
					hcnt_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= P_HEADER;
			hcnt_q <= '0;
			expect_q <= '0;
			done_q <= '0;
			skip_q <= 1'b0;
		end else if (push) begin
			pos_q <= pos_d;
			hcnt_q <= hcnt_d;
			expect_q <= expect_d;
			done_q <= done_d;
			skip_q <= skip_d;
		end
	end

endmodule

[hdl/spmp_queue.sv]
module spmp_queue #(
	parameter int unsigned DEPTH = spmp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spmp_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output spmp_pkg::op_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	spmp_pkg::op_t        mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (do_pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

[hdl/spmp_back.sv]
module spmp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  spmp_pkg::op_t q_op,
	output logic          pop,
	spmp_out_if.source    phase
);

	logic [15:0] id_q, id_d;
	logic [31:0] ts_q, ts_d;
	logic [7:0]  grp_q, grp_d;
	logic [7:0]  st_q, st_d;
	logic        has_q, has_d;
	logic [15:0] tim_q, tim_d;
	logic        vld_q;
	logic        take;

	// pop whenever the output slot is free or being drained
	assign pop = q_valid && (!vld_q || phase.ready);
	assign take = pop && q_op.emit;
	assign phase.valid = vld_q;

	always_comb begin
		id_d = id_q;
		ts_d = ts_q;
		grp_d = grp_q;
		st_d = st_q;
		has_d = has_q;
		tim_d = tim_q;
		case (q_op.load)
			spmp_pkg::LD_ID:     id_d = {id_q[7:0], q_op.data};
			spmp_pkg::LD_TS:     ts_d = {ts_q[23:0], q_op.data};
			spmp_pkg::LD_GROUP: begin
				grp_d = q_op.data;
				st_d = '0;
				has_d = 1'b0;
				tim_d = '0;
			end
			spmp_pkg::LD_STATE:  st_d = q_op.data;
			spmp_pkg::LD_HAS: begin
				has_d = (q_op.data != 8'd0);
				tim_d = '0;
			end
			spmp_pkg::LD_TIMEHI: tim_d = {q_op.data, 8'd0};
			spmp_pkg::LD_TIMELO: tim_d = {tim_q[15:8], q_op.data};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			id_q <= id_d;
			ts_q <= ts_d;
			grp_q <= grp_d;
			st_q <= st_d;
			has_q <= has_d;
			tim_q <= tim_d;
		end
		if (take) begin
			phase.intersection_id <= q_op.hdr ? id_d : '0;
			phase.timestamp_ms <= q_op.hdr ? ts_d : '0;
			phase.phase_index <= q_op.idx;
			phase.signal_group <= q_op.phase ? grp_d : '0;
			phase.phase_state <= q_op.phase ? st_d : '0;
			phase.has_time <= q_op.phase ? has_d : 1'b0;
			phase.time_to_change_ms <= q_op.phase ? tim_d : '0;
			phase.status <= q_op.status;
			phase.message_end <= q_op.mend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= 1'b1;
		end else if (phase.ready) begin
			vld_q <= 1'b0;
		end
	end

endmodule

[hdl/signal_phase_message_parser.sv]
// channel | dir | payload                                   | handshake
// msg     | in  | data_byte[7:0], buffer_end                | valid/ready
// phase   | out | id, timestamp, index, group, state, time, | valid/ready
//         |     | has_time, status[2:0], message_end        |
// apb     | in  | max_phase_count at 0x0                    | psel/penable, pready=1
//
// One byte per cycle while the queue is not full; a result is held first in the queue
// (queue write), then in the output register.
// Front classifies each byte against the parse position and pushes a load/emit
// word into a small queue; back applies the field load and fills the output register.
// arst_n clears parse position, queue pointers and output valid.
// A stalled output fills the queue; msg.ready drops only when the queue is full.
module signal_phase_message_parser #(
	parameter int unsigned QUEUE_DEPTH = spmp_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	spmp_in_if.sink                           msg,
	spmp_out_if.source                        phase,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spmp_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [spmp_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [spmp_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	logic [7:0]    max_phase_q;
	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_valid;
	spmp_pkg::op_t push_op;
	spmp_pkg::op_t head_op;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr == spmp_pkg::REG_MAX_PHASE)
		? {{(spmp_pkg::CFG_DATA_W - 8){1'b0}}, max_phase_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_phase_q <= spmp_pkg::MAX_PHASE_RESET;
		end else if (psel && penable && pwrite && paddr == spmp_pkg::REG_MAX_PHASE) begin
			max_phase_q <= pwdata[7:0];
		end
	end

	// front: parse position tracking and byte classification
	spmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.max_phase (max_phase_q),
		.q_full    (q_full),
		.push      (q_push),
		.op        (push_op)
	);

	spmp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head_op)
	);

	// back: field assembly and result register
	spmp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (head_op),
		.pop     (q_pop),
		.phase   (phase)
	);

endmodule

[tb/tb_signal_phase_message_parser.sv]
module tb_signal_phase_message_parser;
	timeunit 1ns;
	timeprecision 1ps;

	// Watchdog: cycles with no word moving on either channel. The longest
	// legal quiet stretch is the forced receiver hold plus a drain, far below.
	localparam int QUIET_LIMIT = 2000;
	// Receiver hold long enough to fill the internal queue and stall input.
	localparam int LONG_HOLD_CYCLES = 120;
	// A byte that makes no result can still sit in the queue once the last
	// expected result is out; give it time to leave before touching config.
	localparam int DRAIN_CYCLES = spmp_pkg::QUEUE_DEPTH + 6;
	localparam int PHASE_BYTES = 120;

	// parse position of the predictor
	typedef enum logic [2:0] {
		P_HEADER,
		P_GROUP,
		P_STATE,
		P_HASTIME,
		P_TIMEHI,
		P_TIMELO
	} parse_pos_t;

	// one input word as queued for the driver
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_word_t;

	// one phase result as it should appear on the output channel
	typedef struct packed {
		logic [15:0]        id;
		logic [31:0]        ts;
		logic [7:0]         idx;
		logic [7:0]         grp;
		logic [7:0]         pstate;
		logic               has;
		logic [15:0]        ttc;
		spmp_pkg::status_t  status;
		logic               mend;
	} phase_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [spmp_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [spmp_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [spmp_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	spmp_in_if msg_if();
	spmp_out_if res_if();

	signal_phase_message_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg_if),
		.phase   (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stimulus and expectation stores
	msg_word_t     byte_feed_q[$];
	phase_result_t expected_phase_q[$];

	int tx_idle_pct = 11;
	int rx_idle_pct = 74;
	bit long_hold_req = 1'b0;
	bit long_hold_done;
	int rx_hold_left;
	int quiet_cycles;

	int bytes_queued = 0;
	int bytes_accepted = 0;
	int buffers_seen = 0;
	int results_seen = 0;
	int msg_ends_seen = 0;
	int status_hits[8];
	int mismatch_count = 0;
	int cfg_errors = 0;

	// Predictor state: a mirror of the parser, updated per accepted word
	logic [7:0]  max_cfg;
	parse_pos_t  pos;
	logic [2:0]  hdr_cnt;
	logic [15:0] id_acc;
	logic [31:0] ts_acc;
	logic [7:0]  want_n;
	logic [7:0]  done_n;
	logic [7:0]  cur_grp;
	logic [7:0]  cur_pstate;
	logic        cur_has;
	logic [15:0] cur_ttc;
	logic        skipping;

	// Build one expected result. Header and phase fields read as zero when
	// the case calls for it (too short, truncated inside a phase, zero count).
	task automatic emit_result(input bit with_hdr, input logic [7:0] idx,
			input bit with_phase, input spmp_pkg::status_t st, input bit mend);
		phase_result_t r;
		r.id     = with_hdr ? id_acc : 16'h0;
		r.ts     = with_hdr ? ts_acc : 32'h0;
		r.idx    = idx;
		r.grp    = with_phase ? cur_grp : 8'h0;
		r.pstate = with_phase ? cur_pstate : 8'h0;
		r.has    = with_phase ? cur_has : 1'b0;
		r.ttc    = with_phase ? cur_ttc : 16'h0;
		r.status = st;
		r.mend   = mend;
		expected_phase_q.insert(expected_phase_q.size(), r);
	endtask

	task automatic restart_header();
		pos      = P_HEADER;
		hdr_cnt  = '0;
		skipping = 1'b0;
	endtask

	// Message done: either the buffer ends here, or the rest is trailer.
	task automatic close_message(input bit last);
		if (last) begin
			restart_header();
		end else begin
			skipping = 1'b1;
		end
	endtask

	task automatic cut_inside_phase();
		emit_result(1'b1, done_n, 1'b0, spmp_pkg::ST_TRUNC, 1'b1);
		restart_header();
	endtask

	task automatic phase_finished(input bit last);
		logic [7:0] idx;
		idx    = done_n;
		done_n = done_n + 8'd1;
		if (done_n == want_n) begin
			// last declared phase: status depends on the count limit
			emit_result(1'b1, idx, 1'b1,
				(want_n > max_cfg) ? spmp_pkg::ST_BADCOUNT : spmp_pkg::ST_OK, 1'b1);
			close_message(last);
		end else if (last) begin
			// buffer ran out right after a phase that was not the last one
			emit_result(1'b1, idx, 1'b1, spmp_pkg::ST_TRUNC, 1'b1);
			restart_header();
		end else begin
			emit_result(1'b1, idx, 1'b1, spmp_pkg::ST_PHASE, 1'b0);
			pos = P_GROUP;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		if (skipping) begin
			if (last) begin
				restart_header();
			end
		end else begin
			case (pos)
				P_HEADER: begin
					if (hdr_cnt == 3'(spmp_pkg::HDR_BYTES - 1)) begin
						want_n  = b;
						done_n  = 8'd0;
						hdr_cnt = '0;
						if (b == 8'd0) begin
							// zero count fails on the count byte itself
							emit_result(1'b1, 8'd0, 1'b0, spmp_pkg::ST_BADCOUNT, 1'b1);
							close_message(last);
						end else begin
							pos = P_GROUP;
							if (last) begin
								cut_inside_phase();
							end
						end
					end else begin
						if (hdr_cnt < spmp_pkg::ID_BYTES) begin
							id_acc = {id_acc[7:0], b};
						end else begin
							ts_acc = {ts_acc[23:0], b};
						end
						hdr_cnt = hdr_cnt + 3'd1;
						if (last) begin
							emit_result(1'b0, 8'd0, 1'b0, spmp_pkg::ST_SHORT, 1'b1);
							restart_header();
						end
					end
				end
				P_GROUP: begin
					cur_grp    = b;
					cur_pstate = 8'h0;
					cur_has    = 1'b0;
					cur_ttc    = 16'h0;
					pos        = P_STATE;
					if (last) begin
						cut_inside_phase();
					end
				end
				P_STATE: begin
					cur_pstate = b;
					pos        = P_HASTIME;
					if (last) begin
						cut_inside_phase();
					end
				end
				P_HASTIME: begin
					cur_ttc = 16'h0;
					if (b != 8'h0) begin
						cur_has = 1'b1;
						pos     = P_TIMEHI;
						if (last) begin
							cut_inside_phase();
						end
					end else begin
						cur_has = 1'b0;
						phase_finished(last);
					end
				end
				P_TIMEHI: begin
					cur_ttc = {b, 8'h00};
					pos     = P_TIMELO;
					if (last) begin
						cut_inside_phase();
					end
				end
				P_TIMELO: begin
					cur_ttc[7:0] = b;
					phase_finished(last);
				end
				default: begin
					restart_header();
				end
			endcase
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Driver: next word from the feed queue, with random gaps
	always @(posedge clk) begin
		msg_word_t w;
		if (!arst_n) begin
			msg_if.valid <= 1'b0;
		end else if (!msg_if.valid || msg_if.ready) begin
			if (byte_feed_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
				w = byte_feed_q.pop_front();
				msg_if.valid      <= 1'b1;
				msg_if.data_byte  <= w.data;
				msg_if.buffer_end <= w.last;
			end else begin
				msg_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready   <= 1'b0;
			rx_hold_left   <= 0;
			long_hold_done <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			res_if.ready   <= 1'b0;
			rx_hold_left   <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else if (rx_hold_left != 0) begin
			res_if.ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			res_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
		end
	end

	// Monitor: predict on every accepted input word, then check the result
	// word against the oldest expectation. A result passes the queue and the output register,
	// so a word predicted here never matches a result in the same edge.
	always @(posedge clk) begin
		phase_result_t want_r;
		if (arst_n) begin
			if (msg_if.valid && msg_if.ready) begin
				parse_byte(msg_if.data_byte, msg_if.buffer_end);
				bytes_accepted++;
				if (msg_if.buffer_end) begin
					buffers_seen++;
				end
			end
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				if (expected_phase_q.size() == 0) begin
					$error("result word with nothing expected: id 0x%0h index %0d status %0d",
						res_if.intersection_id, res_if.phase_index, res_if.status);
					mismatch_count++;
				end else begin
					want_r = expected_phase_q.pop_front();
					check_field("intersection_id", want_r.id, res_if.intersection_id);
					check_field("timestamp_ms", want_r.ts, res_if.timestamp_ms);
					check_field("phase_index", want_r.idx, res_if.phase_index);
					check_field("signal_group", want_r.grp, res_if.signal_group);
					check_field("phase_state", want_r.pstate, res_if.phase_state);
					check_field("has_time", want_r.has, res_if.has_time);
					check_field("time_to_change_ms", want_r.ttc, res_if.time_to_change_ms);
					check_field("status", want_r.status, res_if.status);
					check_field("message_end", want_r.mend, res_if.message_end);
					status_hits[want_r.status]++;
					if (want_r.mend) begin
						msg_ends_seen++;
					end
				end
			end
		end
	end

	// Watchdog on lack of progress
	always @(posedge clk) begin
		if (!arst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", quiet_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic feed_byte(input logic [7:0] b, input bit last);
		msg_word_t w;
		w.data = b;
		w.last = last;
		byte_feed_q.insert(byte_feed_q.size(), w);
		bytes_queued++;
	endtask

	// One message with random header and phase content. cut_len > 0 ends the
	// buffer after that many bytes (if shorter than the message); otherwise
	// trailer_len junk bytes follow. timed = 0 keeps every has-time byte zero.
	task automatic queue_message(input logic [7:0] count, input int cut_len,
			input int trailer_len, input bit timed);
		logic [7:0]  msg_q[$];
		logic [55:0] hdr;
		logic [7:0]  has_b;
		hdr = {16'($urandom), 32'($urandom), count};
		for (int k = 6; k >= 0; k--) begin
			msg_q.insert(msg_q.size(), hdr[k*8 +: 8]);
		end
		for (int i = 0; i < count; i++) begin
			has_b = (timed && $urandom_range(1, 0)) ? 8'($urandom_range(255, 1)) : 8'h00;
			msg_q.insert(msg_q.size(), 8'($urandom));
			msg_q.insert(msg_q.size(), 8'($urandom));
			msg_q.insert(msg_q.size(), has_b);
			if (has_b != 8'h00) begin
				msg_q.insert(msg_q.size(), 8'($urandom));
				msg_q.insert(msg_q.size(), 8'($urandom));
			end
		end
		if (cut_len > 0 && cut_len < msg_q.size()) begin
			while (msg_q.size() > cut_len) begin
				void'(msg_q.pop_back());
			end
		end else begin
			repeat (trailer_len) msg_q.insert(msg_q.size(), 8'($urandom));
		end
		foreach (msg_q[i]) begin
			feed_byte(msg_q[i], i == msg_q.size() - 1);
		end
	endtask

	// Mostly complete messages; the rest cut short, zero count, or noise.
	task automatic random_traffic(input int target);
		int base;
		int pick;
		int n;
		base = bytes_queued;
		while (bytes_queued - base < target) begin
			pick = $urandom_range(99, 0);
			if (pick < 60) begin
				n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 7) : $urandom_range(4, 1);
				queue_message(8'(n), 0, $urandom_range(2, 0), 1'b1);
			end else if (pick < 70) begin
				queue_message(8'($urandom_range(4, 1)), $urandom_range(6, 1), 0, 1'b1);
			end else if (pick < 85) begin
				// cut anywhere from right after the count to the last byte
				n = $urandom_range(5, 1);
				queue_message(8'(n), $urandom_range(7 + 5 * n - 1, 7), 0, 1'b1);
			end else if (pick < 93) begin
				queue_message(8'h00, 0, $urandom_range(3, 0), 1'b1);
			end else begin
				n = $urandom_range(10, 1);
				for (int i = 0; i < n; i++) begin
					feed_byte(8'($urandom), i == n - 1);
				end
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (bytes_accepted != bytes_queued || expected_phase_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write of the count limit, then read it back
	task automatic write_max_phase(input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= spmp_pkg::REG_MAX_PHASE;
		pwdata  <= spmp_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		max_cfg = val;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata[7:0] !== val) begin
			$error("max_phase_count readback: expected 0x%0h, got 0x%0h", val, prdata[7:0]);
			cfg_errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int phase_base;
		msg_if.valid      = 1'b0;
		msg_if.data_byte  = 8'h00;
		msg_if.buffer_end = 1'b0;
		res_if.ready      = 1'b0;
		max_cfg           = spmp_pkg::MAX_PHASE_RESET;
		id_acc            = '0;
		ts_acc            = '0;
		want_n            = '0;
		done_n            = '0;
		cur_grp           = '0;
		cur_pstate        = '0;
		cur_has           = 1'b0;
		cur_ttc           = '0;
		restart_header();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, limit at its reset value. Sender mostly busy, receiver
		// mostly stalled.
		// buffer of one byte: too short
		feed_byte(8'hFF, 1'b1);
		// all-ones id and timestamp, count of one, one timed phase of all ones: ok
		repeat (6) feed_byte(8'hFF, 1'b0);
		feed_byte(8'h01, 1'b0);
		repeat (4) feed_byte(8'hFF, 1'b0);
		feed_byte(8'hFF, 1'b1);
		// all-zero header with zero count, then a trailer byte
		repeat (7) feed_byte(8'h00, 1'b0);
		feed_byte(8'h5A, 1'b1);
		// buffer ends on the count byte: truncated at phase 0
		repeat (6) feed_byte(8'h3C, 1'b0);
		feed_byte(8'h03, 1'b1);
		wait_drained();

		// limit of one: every count above one is over the maximum
		write_max_phase(8'd1);
		random_traffic(PHASE_BYTES);
		wait_drained();

		// roles swapped: sender mostly idle, receiver mostly ready
		tx_idle_pct = 74;
		rx_idle_pct = 11;
		write_max_phase(8'd255);
		random_traffic(PHASE_BYTES);
		wait_drained();

		write_max_phase(8'($urandom_range(8, 3)));
		random_traffic(PHASE_BYTES);
		wait_drained();

		// no idling at all; one long receiver hold while input keeps coming,
		// then a message whose count is one over the limit
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_max_phase(8'd40);
		phase_base = bytes_accepted;
		random_traffic(PHASE_BYTES);
		queue_message(8'd41, 0, 1, 1'b0);
		while (bytes_accepted < phase_base + 20) @(negedge clk);
		long_hold_req = 1'b1;
		wait_drained();

		$display("Covered %0d bytes in %0d buffers; %0d result words, %0d message ends",
			bytes_accepted, buffers_seen, results_seen, msg_ends_seen);
		$display("Statuses seen: phase %0d, ok %0d, short %0d, truncated %0d, bad count %0d",
			status_hits[spmp_pkg::ST_PHASE], status_hits[spmp_pkg::ST_OK],
			status_hits[spmp_pkg::ST_SHORT], status_hits[spmp_pkg::ST_TRUNC],
			status_hits[spmp_pkg::ST_BADCOUNT]);
		if (mismatch_count == 0 && cfg_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
hdl/spmp_pkg.sv
hdl/spmp_ifs.sv
hdl/spmp_front.sv
hdl/spmp_queue.sv
hdl/spmp_back.sv
hdl/signal_phase_message_parser.sv
tb/tb_signal_phase_message_parser.sv
